FILE: rtl/piecewise_linear_table_eval_top_macros.svh
// Assertion macros for the files that check their own logic.
// Each macro expects the signals clk and arst_n to exist in the module that uses it.
`ifndef PIECEWISE_LINEAR_TABLE_EVAL_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_EVAL_TOP_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define PLTE_ASSERT_NOW(label, cond, consq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (consq)) \
		else $error(msg);

// The condition implies the consequence in the next cycle.
`define PLTE_ASSERT_NEXT(label, cond, consq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (consq)) \
		else $error(msg);

`endif

FILE: rtl/plte_pkg.sv
`default_nettype none
package plte_pkg;

	// Value format is signed Q16.16.
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SUM_W     = PROD_W - FRAC_W + 1;
	localparam int SEG_IDX_W = 8;
	localparam int SEG_CNT_W = 9;
	localparam int STEP_W    = 32;

	localparam int DEF_TABLE_DEPTH = 256;

	// Configuration port.
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_ADDR_W = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_START_X    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_END_X      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_STEP   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SEG_COUNT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_USE_LOW    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_USE_HIGH   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd7;

	localparam logic [VAL_W-1:0]     RST_INV_STEP  = 32'd65536;
	localparam logic [SEG_CNT_W-1:0] RST_SEG_COUNT = 9'd256;

	// Request opcodes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// Result source codes.
	localparam logic [1:0] SRC_LINE = 2'd0;
	localparam logic [1:0] SRC_LOW  = 2'd1;
	localparam logic [1:0] SRC_HIGH = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0]     start_x;
		logic [VAL_W-1:0]     end_x;
		logic [STEP_W-1:0]    inverse_step;
		logic [SEG_CNT_W-1:0] segments_in_use;
		logic                 use_low_limit;
		logic                 use_high_limit;
		logic [VAL_W-1:0]     low_limit_value;
		logic [VAL_W-1:0]     high_limit_value;
	} cfg_t;

	typedef struct packed {
		logic [VAL_W-1:0] slope;
		logic [VAL_W-1:0] intercept;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// Sideband of an evaluate request travelling next to the table read.
	typedef struct packed {
		logic             valid;
		logic [1:0]       src;
		logic [VAL_W-1:0] x;
	} side_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] y;
		logic [1:0]       src;
		logic             sat;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/plte_seg_mem.sv
`default_nettype none
module plte_seg_mem
	import plte_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire mem_ctl_t      ctl,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	output entry_t             rd_data_s3
);

	entry_t mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data is held while the pipeline stalls.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_s3 <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/plte_addr_gen.sv
`default_nettype none
module plte_addr_gen
	import plte_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_take,
	input  wire logic                 opcode,
	input  wire logic [SEG_IDX_W-1:0] segment_index,
	input  wire logic [VAL_W-1:0]     slope_in,
	input  wire logic [VAL_W-1:0]     intercept_in,
	input  wire logic [VAL_W-1:0]     x_value,
	input  wire cfg_t                 cfg,
	output mem_ctl_t                  mem_ctl,
	output logic [AW-1:0]             rd_addr,
	output logic [AW-1:0]             wr_addr,
	output entry_t                    wr_data,
	output side_t                     side_s2
);

	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	logic below, above;
	logic [1:0] src_in;
	logic [VAL_W-1:0] diff_in;

	logic                 v_s1, eval_s1, in_range_s1;
	logic [1:0]           src_s1;
	logic [VAL_W-1:0]     x_s1, diff_s1;
	logic [SEG_IDX_W-1:0] widx_s1;
	entry_t               wdata_s1;

	logic                 v_s2, eval_s2, in_range_s2;
	logic [1:0]           src_s2;
	logic [VAL_W-1:0]     x_s2;
	logic [31:0]          raw_s2;
	logic [SEG_IDX_W-1:0] widx_s2;
	entry_t               wdata_s2;

	logic [PROD_W-1:0] idx_prod;
	logic [31:0] seg32, bound, idx32;

	// Range tests happen at accept; the low test wins when start is above end.
	always_comb begin
		below   = $signed(x_value) < $signed(cfg.start_x);
		above   = $signed(x_value) > $signed(cfg.end_x);
		diff_in = x_value - cfg.start_x;
		src_in  = SRC_LINE;
		if (below) begin
			if (cfg.use_low_limit) begin
				src_in = SRC_LOW;
			end
		end else if (above) begin
			if (cfg.use_high_limit) begin
				src_in = SRC_HIGH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eval_s1     <= (opcode == OP_EVAL);
			in_range_s1 <= !below && !above;
			src_s1      <= src_in;
			x_s1        <= x_value;
			diff_s1     <= diff_in;
			widx_s1     <= segment_index;
			wdata_s1    <= '{slope: slope_in, intercept: intercept_in};

			eval_s2     <= eval_s1;
			in_range_s2 <= in_range_s1;
			src_s2      <= src_s1;
			x_s2        <= x_s1;
			raw_s2      <= idx_prod[PROD_W-1:VAL_W];
			widx_s2     <= widx_s1;
			wdata_s2    <= wdata_s1;
		end
	end

	// Segment position: integer part of (x - start) * inverse_step.
	assign idx_prod = PROD_W'(diff_s1) * PROD_W'(cfg.inverse_step);

	always_comb begin
		seg32 = 32'(cfg.segments_in_use);
		if (seg32 == 32'd0) begin
			bound = 32'd1;
		end else if (seg32 > DEPTH32) begin
			bound = DEPTH32;
		end else begin
			bound = seg32;
		end
		idx32 = (raw_s2 >= bound) ? bound - 32'd1 : raw_s2;
	end

	// Reads and writes of the table both happen here, in request order.
	assign mem_ctl.rd_en = en && v_s2 && eval_s2;
	assign mem_ctl.wr_en = en && v_s2 && !eval_s2 && (32'(widx_s2) < DEPTH32);
	assign rd_addr = in_range_s2 ? idx32[AW-1:0] : '0;
	assign wr_addr = AW'(widx_s2);
	assign wr_data = wdata_s2;

	assign side_s2.valid = v_s2 && eval_s2;
	assign side_s2.src   = src_s2;
	assign side_s2.x     = x_s2;

endmodule
`default_nettype wire

FILE: rtl/plte_line_eval.sv
`default_nettype none
module plte_line_eval
	import plte_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire side_t  side_s2,
	input  wire entry_t rd_data_s3,
	input  wire cfg_t   cfg,
	output res_t        res_s4
);

	logic              v_s3;
	logic [1:0]        src_s3;
	logic [VAL_W-1:0]  x_s3;
	logic              v_s4;
	logic [1:0]        src_s4;
	logic signed [PROD_W-1:0] prod_s4;
	logic signed [VAL_W-1:0]  icpt_s4;

	logic signed [SUM_W-1:0] sum;
	logic pos_ovf, neg_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= side_s2.valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_s3  <= side_s2.src;
			x_s3    <= side_s2.x;
			src_s4  <= src_s3;
			prod_s4 <= PROD_W'($signed(rd_data_s3.slope)) * PROD_W'($signed(x_s3));
			icpt_s4 <= $signed(rd_data_s3.intercept);
		end
	end

	// Arithmetic shift floors the product; the intercept is added exactly.
	assign sum = SUM_W'(prod_s4 >>> FRAC_W) + SUM_W'(icpt_s4);
	assign pos_ovf = !sum[SUM_W-1] && (|sum[SUM_W-2:VAL_W-1]);
	assign neg_ovf = sum[SUM_W-1] && !(&sum[SUM_W-2:VAL_W-1]);

	always_comb begin
		res_s4.valid = v_s4;
		res_s4.src   = src_s4;
		res_s4.sat   = 1'b0;
		case (src_s4)
			SRC_LOW: begin
				res_s4.y = cfg.low_limit_value;
			end
			SRC_HIGH: begin
				res_s4.y = cfg.high_limit_value;
			end
			default: begin
				res_s4.sat = pos_ovf || neg_ovf;
				if (pos_ovf) begin
					res_s4.y = {1'b0, {(VAL_W-1){1'b1}}};
				end else if (neg_ovf) begin
					res_s4.y = {1'b1, {(VAL_W-1){1'b0}}};
				end else begin
					res_s4.y = sum[VAL_W-1:0];
				end
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/piecewise_linear_table_eval_top.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   opcode, segment_index, slope_in, intercept_in, x_value
// out       out_valid / out_ready y_value, result_source, saturated
// cfg       psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// One request is taken every cycle unless the pipeline stalls.
// The segment table memory is touched at most once per request, in request order.
// Reset loads the configuration defaults and clears the pipeline valid bits; table contents are undefined.
// The pipeline stalls only when a result sits in the output register unclaimed and another
// result is ready to replace it; every stage then holds, bubbles included.
`default_nettype none
`include "piecewise_linear_table_eval_top_macros.svh"
module piecewise_linear_table_eval_top
	import plte_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  opcode,
	input  wire logic [SEG_IDX_W-1:0]  segment_index,
	input  wire logic [VAL_W-1:0]      slope_in,
	input  wire logic [VAL_W-1:0]      intercept_in,
	input  wire logic [VAL_W-1:0]      x_value,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [VAL_W-1:0]           y_value,
	output logic [1:0]                 result_source,
	output logic                       saturated,

	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	cfg_t cfg_q;

	logic en, in_take, cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t        wr_data, rd_data_s3;
	side_t         side_s2;
	res_t          res_s4;

	logic             out_valid_q, sat_q;
	logic [VAL_W-1:0] y_q;
	logic [1:0]       src_q;
	logic             limit_out;

	// Every stage advances together unless the finished result in the last stage would
	// overwrite an output that the consumer has not taken yet.
	assign en       = !(res_s4.valid && out_valid_q && !out_ready);
	assign in_ready = en;
	assign in_take  = in_valid && in_ready;

	// Configuration registers. Writes land on the access phase of the transfer.
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x          <= '0;
			cfg_q.end_x            <= '0;
			cfg_q.inverse_step     <= RST_INV_STEP;
			cfg_q.segments_in_use  <= RST_SEG_COUNT;
			cfg_q.use_low_limit    <= 1'b1;
			cfg_q.use_high_limit   <= 1'b1;
			cfg_q.low_limit_value  <= '0;
			cfg_q.high_limit_value <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_START_X:    cfg_q.start_x          <= pwdata[VAL_W-1:0];
				REG_END_X:      cfg_q.end_x            <= pwdata[VAL_W-1:0];
				REG_INV_STEP:   cfg_q.inverse_step     <= pwdata[STEP_W-1:0];
				REG_SEG_COUNT:  cfg_q.segments_in_use  <= pwdata[SEG_CNT_W-1:0];
				REG_USE_LOW:    cfg_q.use_low_limit    <= pwdata[0];
				REG_USE_HIGH:   cfg_q.use_high_limit   <= pwdata[0];
				REG_LOW_LIMIT:  cfg_q.low_limit_value  <= pwdata[VAL_W-1:0];
				REG_HIGH_LIMIT: cfg_q.high_limit_value <= pwdata[VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back returns each register zero-extended to the bus width.
	always_comb begin
		case (reg_idx)
			REG_START_X:    prdata = CFG_DATA_W'(cfg_q.start_x);
			REG_END_X:      prdata = CFG_DATA_W'(cfg_q.end_x);
			REG_INV_STEP:   prdata = CFG_DATA_W'(cfg_q.inverse_step);
			REG_SEG_COUNT:  prdata = CFG_DATA_W'(cfg_q.segments_in_use);
			REG_USE_LOW:    prdata = CFG_DATA_W'(cfg_q.use_low_limit);
			REG_USE_HIGH:   prdata = CFG_DATA_W'(cfg_q.use_high_limit);
			REG_LOW_LIMIT:  prdata = CFG_DATA_W'(cfg_q.low_limit_value);
			REG_HIGH_LIMIT: prdata = CFG_DATA_W'(cfg_q.high_limit_value);
			default:        prdata = '0;
		endcase
	end

	// Stages one and two: range tests, segment position multiply, clamp, and the table access.
	plte_addr_gen #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_addr_gen (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_take      (in_take),
		.opcode       (opcode),
		.segment_index(segment_index),
		.slope_in     (slope_in),
		.intercept_in (intercept_in),
		.x_value      (x_value),
		.cfg          (cfg_q),
		.mem_ctl      (mem_ctl),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.side_s2      (side_s2)
	);

	// Slope and intercept table. Because a write and a later read of the same entry
	// reach the memory in separate cycles and in order, no forwarding is needed.
	plte_seg_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seg_mem (
		.clk       (clk),
		.ctl       (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_data_s3(rd_data_s3)
	);

	// Stages three and four: slope times x, floor to Q16.16, add the intercept, saturate.
	plte_line_eval u_line_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.side_s2   (side_s2),
		.rd_data_s3(rd_data_s3),
		.cfg       (cfg_q),
		.res_s4    (res_s4)
	);

	// Output register: lets the pipeline keep moving while a result waits for the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && res_s4.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_s4.valid) begin
			y_q   <= res_s4.y;
			src_q <= res_s4.src;
			sat_q <= res_s4.sat;
		end
	end

	assign out_valid     = out_valid_q;
	assign y_value       = y_q;
	assign result_source = src_q;
	assign saturated     = sat_q;

	// A limit value leaves the block as stored, never clipped.
	assign limit_out = out_valid && (result_source != SRC_LINE);

	`PLTE_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "stall without blocked output")
	`PLTE_ASSERT_NOW(a_one_access, mem_ctl.rd_en, !mem_ctl.wr_en, "table read and write together")
	`PLTE_ASSERT_NOW(a_limit_unsat, limit_out, !saturated, "limit result flagged saturated")
	`PLTE_ASSERT_NEXT(a_result_loaded, en && res_s4.valid, out_valid, "result not captured")

endmodule
`default_nettype wire
